### src/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg: shared types and constants for pressure sensor compensation
// Widths of the intermediate values, calibration register indexes, the
// calibration bundle and the records passed between pipeline sections.
// ----------------------------------------------------------------------------
package psc_pkg;

    localparam int RAW_W      = 24;
    localparam int CAL_W      = 16;
    localparam int IDX_W      = 3;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;

    // calibration register indexes
    localparam logic [IDX_W-1:0] REG_C1 = 3'd0;
    localparam logic [IDX_W-1:0] REG_C2 = 3'd1;
    localparam logic [IDX_W-1:0] REG_C3 = 3'd2;
    localparam logic [IDX_W-1:0] REG_C4 = 3'd3;
    localparam logic [IDX_W-1:0] REG_C5 = 3'd4;
    localparam int               REG_C5_SHIFT = 8;
    localparam logic [IDX_W-1:0] REG_C6 = 3'd5;

    // temperature path
    localparam int DT_W        = RAW_W + 1;
    localparam int PFULL_W     = DT_W + CAL_W + 1;
    localparam int PTC_W       = 41;
    localparam int DD_W        = 48;
    localparam int TEMP_SHIFT  = 23;
    localparam int T2_LO_SHIFT = 33;
    localparam int T2_HI_SHIFT = 37;
    localparam int DDH_W       = DD_W - T2_LO_SHIFT;
    localparam int DD7_W       = DD_W + 3;
    localparam int T2H_W       = DD7_W - T2_HI_SHIFT;
    localparam int T2_W        = DDH_W + 2;
    localparam int DEV_W       = PTC_W - TEMP_SHIFT;
    localparam int LOW_W       = DEV_W + 1;
    localparam int TRAW_W      = DEV_W + 1;
    localparam int OFF_SHIFT   = 7;
    localparam int SENS_SHIFT  = 8;
    localparam int C2_SHIFT    = 16;
    localparam int C1_SHIFT    = 15;

    // correction and pressure path
    localparam int SQ_W        = 34;
    localparam int CORR_W      = 40;
    localparam int SPLIT       = 20;
    localparam int PLO_W       = SPLIT + RAW_W;
    localparam int PHI_W       = CORR_W - SPLIT + RAW_W + 1;
    localparam int PROD_W      = 64;
    localparam int PROD_SHIFT  = 21;
    localparam int PSH_W       = PROD_W - PROD_SHIFT + 1;
    localparam int PRES_SHIFT  = 15;
    localparam int PRAW_W      = PSH_W - PRES_SHIFT;

    localparam int TEMP_W      = 15;
    localparam int PRES_W      = 18;

    localparam logic signed [TRAW_W-1:0] TEMP_BASE  = 19'sd2000;
    // dev below this means first-order temperature below -15.00 C
    localparam logic signed [DEV_W-1:0]  VLOW_DEV   = -18'sd3500;
    localparam logic signed [LOW_W-1:0]  VLOW_SHIFT = 19'sd3500;
    localparam logic signed [TRAW_W-1:0] TEMP_MIN   = -19'sd4000;
    localparam logic signed [TRAW_W-1:0] TEMP_MAX   = 19'sd8500;
    localparam logic signed [PRAW_W-1:0] PRES_MAX   = 29'sd140000;

    typedef struct packed {
        logic [CAL_W-1:0] c1;   // sensitivity base
        logic [CAL_W-1:0] c2;   // offset base
        logic [CAL_W-1:0] c3;   // sensitivity temperature coefficient
        logic [CAL_W-1:0] c4;   // offset temperature coefficient
        logic [CAL_W-1:0] c5;   // reference temperature / 256
        logic [CAL_W-1:0] c6;   // temperature coefficient
    } cal_t;

    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [TRAW_W-1:0] temp;
        logic signed [DEV_W-1:0]  dev;
        logic signed [LOW_W-1:0]  low;
        logic                     low_range;
        logic                     vlow_range;
        logic [CORR_W-1:0]        off1;
        logic [CORR_W-1:0]        sens1;
    } temp_res_t;

    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [TRAW_W-1:0] temp;
        logic [CORR_W-1:0]        off;
        logic [CORR_W-1:0]        sens;
    } corr_res_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic [PRES_W-1:0]        pres;
        logic                     sat;
    } comp_res_t;

endpackage

### src/psc_temp.sv
// ----------------------------------------------------------------------------
// psc_temp: temperature difference, products and first-order terms
// Three stages: dT, the four dT products, then TEMP, T2, OFF1 and SENS1.
// ----------------------------------------------------------------------------
module psc_temp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  psc_pkg::cal_t              cal,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [psc_pkg::RAW_W-1:0]  in_d2,
    input  logic [psc_pkg::RAW_W-1:0]  in_d1,
    output logic                       out_valid,
    input  logic                       out_ready,
    output psc_pkg::temp_res_t         out_data
);
    import psc_pkg::*;

    localparam int NS = 3;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS:0]   adv;

    logic signed [DT_W-1:0]    s1_dt_reg;
    logic signed [DT_W-1:0]    s1_dt_next;
    logic [RAW_W-1:0]          s1_d1_reg;

    logic signed [PFULL_W-1:0] tc_full;
    logic signed [PFULL_W-1:0] off_full;
    logic signed [PFULL_W-1:0] sens_full;
    logic signed [2*DT_W-1:0]  dd_full;
    logic [PTC_W-1:0]          s2_tc_reg;
    logic [PTC_W-1:0]          s2_off_reg;
    logic [PTC_W-1:0]          s2_sens_reg;
    logic [DD_W-1:0]           s2_dd_reg;
    logic [RAW_W-1:0]          s2_d1_reg;

    logic signed [DEV_W-1:0]   dev;
    logic [DDH_W-1:0]          dd_hi;
    logic [T2_W-1:0]           t2_lo;
    logic [DD7_W-1:0]          dd7;
    logic [T2H_W-1:0]          t2_hi;
    logic [T2_W-1:0]           t2;
    temp_res_t                 s3_reg;
    temp_res_t                 s3_next;

    always_comb
    begin
        adv[NS] = out_ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            adv[i] = ~v_reg[i] | adv[i+1];
        end
    end

    assign v_next    = {v_reg[NS-2:0], in_valid};
    assign in_ready  = adv[0];
    assign out_valid = v_reg[NS-1];
    assign out_data  = s3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (adv[i])
                begin
                    v_reg[i] <= v_next[i];
                end
            end
        end
    end

    // stage 1: dT = D2 - C5 * 256
    assign s1_dt_next = $signed({1'b0, in_d2})
                      - $signed({1'b0, cal.c5, {REG_C5_SHIFT{1'b0}}});

    // stage 2: products of dT
    assign tc_full   = s1_dt_reg * $signed({1'b0, cal.c6});
    assign off_full  = s1_dt_reg * $signed({1'b0, cal.c4});
    assign sens_full = s1_dt_reg * $signed({1'b0, cal.c3});
    assign dd_full   = s1_dt_reg * s1_dt_reg;

    // stage 3: first-order temperature and T2
    always_comb
    begin
        dev   = s2_tc_reg[PTC_W-1:TEMP_SHIFT];
        dd_hi = s2_dd_reg[DD_W-1:T2_LO_SHIFT];
        t2_lo = {2'b00, dd_hi} + {1'b0, dd_hi, 1'b0};
        dd7   = {s2_dd_reg, 3'b000} - {3'b000, s2_dd_reg};
        t2_hi = dd7[DD7_W-1:T2_HI_SHIFT];
        t2    = dev[DEV_W-1] ? t2_lo : {{(T2_W-T2H_W){1'b0}}, t2_hi};

        s3_next.d1         = s2_d1_reg;
        s3_next.dev        = dev;
        s3_next.low        = {dev[DEV_W-1], dev} + VLOW_SHIFT;
        s3_next.low_range  = dev[DEV_W-1];
        s3_next.vlow_range = (dev < VLOW_DEV);
        s3_next.temp       = TEMP_BASE + {dev[DEV_W-1], dev}
                           - {{(TRAW_W-T2_W){1'b0}}, t2};
        s3_next.off1       = {{(CORR_W-CAL_W-C2_SHIFT){1'b0}}, cal.c2, {C2_SHIFT{1'b0}}}
                           + {{(CORR_W-PTC_W+OFF_SHIFT){s2_off_reg[PTC_W-1]}},
                              s2_off_reg[PTC_W-1:OFF_SHIFT]};
        s3_next.sens1      = {{(CORR_W-CAL_W-C1_SHIFT){1'b0}}, cal.c1, {C1_SHIFT{1'b0}}}
                           + {{(CORR_W-PTC_W+SENS_SHIFT){s2_sens_reg[PTC_W-1]}},
                              s2_sens_reg[PTC_W-1:SENS_SHIFT]};
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_dt_reg <= s1_dt_next;
            s1_d1_reg <= in_d1;
        end
        if (adv[1])
        begin
            s2_tc_reg   <= tc_full[PTC_W-1:0];
            s2_off_reg  <= off_full[PTC_W-1:0];
            s2_sens_reg <= sens_full[PTC_W-1:0];
            s2_dd_reg   <= dd_full[DD_W-1:0];
            s2_d1_reg   <= s1_d1_reg;
        end
        if (adv[2])
        begin
            s3_reg <= s3_next;
        end
    end

endmodule

### src/psc_corr.sv
// ----------------------------------------------------------------------------
// psc_corr: second-order offset and sensitivity corrections
// Three stages: squares, OFF2 and SENS2, then the corrected OFF and SENS.
// ----------------------------------------------------------------------------
module psc_corr (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  psc_pkg::temp_res_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output psc_pkg::corr_res_t out_data
);
    import psc_pkg::*;

    localparam int NS = 3;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS:0]   adv;

    logic signed [DEV_W-1:0]   dev;
    logic signed [LOW_W-1:0]   low;
    logic signed [2*DEV_W-1:0] sqd_full;
    logic signed [2*LOW_W-1:0] sql_full;

    logic [SQ_W-1:0]           s4_sqd_reg;
    logic [SQ_W-1:0]           s4_sql_reg;
    logic                      s4_low_reg;
    logic                      s4_vlow_reg;
    logic signed [TRAW_W-1:0]  s4_temp_reg;
    logic [RAW_W-1:0]          s4_d1_reg;
    logic [CORR_W-1:0]         s4_off1_reg;
    logic [CORR_W-1:0]         s4_sens1_reg;

    logic [CORR_W-1:0]         sqd;
    logic [CORR_W-1:0]         sql;
    logic [CORR_W-1:0]         sqd3;
    logic [CORR_W-1:0]         sqd5;
    logic [CORR_W-1:0]         off2_next;
    logic [CORR_W-1:0]         sens2_next;

    logic [CORR_W-1:0]         s5_off2_reg;
    logic [CORR_W-1:0]         s5_sens2_reg;
    logic signed [TRAW_W-1:0]  s5_temp_reg;
    logic [RAW_W-1:0]          s5_d1_reg;
    logic [CORR_W-1:0]         s5_off1_reg;
    logic [CORR_W-1:0]         s5_sens1_reg;

    corr_res_t                 s6_reg;
    corr_res_t                 s6_next;

    always_comb
    begin
        adv[NS] = out_ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            adv[i] = ~v_reg[i] | adv[i+1];
        end
    end

    assign v_next    = {v_reg[NS-2:0], in_valid};
    assign in_ready  = adv[0];
    assign out_valid = v_reg[NS-1];
    assign out_data  = s6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (adv[i])
                begin
                    v_reg[i] <= v_next[i];
                end
            end
        end
    end

    // stage 4: squares of the deviation from 20.00 C and from -15.00 C
    assign dev      = in_data.dev;
    assign low      = in_data.low;
    assign sqd_full = dev * dev;
    assign sql_full = low * low;

    // stage 5: correction terms
    always_comb
    begin
        sqd  = {{(CORR_W-SQ_W){1'b0}}, s4_sqd_reg};
        sql  = {{(CORR_W-SQ_W){1'b0}}, s4_sql_reg};
        sqd3 = sqd + (sqd << 1);
        sqd5 = sqd + (sqd << 2);
        if (s4_low_reg)
        begin
            off2_next  = sqd3 >> 1;
            sens2_next = sqd5 >> 3;
            if (s4_vlow_reg)
            begin
                off2_next  = off2_next + ((sql << 3) - sql);
                sens2_next = sens2_next + (sql << 2);
            end
        end
        else
        begin
            off2_next  = sqd >> 4;
            sens2_next = '0;
        end
    end

    // stage 6: corrected offset and sensitivity
    always_comb
    begin
        s6_next.d1   = s5_d1_reg;
        s6_next.temp = s5_temp_reg;
        s6_next.off  = s5_off1_reg - s5_off2_reg;
        s6_next.sens = s5_sens1_reg - s5_sens2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s4_sqd_reg   <= sqd_full[SQ_W-1:0];
            s4_sql_reg   <= sql_full[SQ_W-1:0];
            s4_low_reg   <= in_data.low_range;
            s4_vlow_reg  <= in_data.vlow_range;
            s4_temp_reg  <= in_data.temp;
            s4_d1_reg    <= in_data.d1;
            s4_off1_reg  <= in_data.off1;
            s4_sens1_reg <= in_data.sens1;
        end
        if (adv[1])
        begin
            s5_off2_reg  <= off2_next;
            s5_sens2_reg <= sens2_next;
            s5_temp_reg  <= s4_temp_reg;
            s5_d1_reg    <= s4_d1_reg;
            s5_off1_reg  <= s4_off1_reg;
            s5_sens1_reg <= s4_sens1_reg;
        end
        if (adv[2])
        begin
            s6_reg <= s6_next;
        end
    end

endmodule

### src/psc_pres.sv
// ----------------------------------------------------------------------------
// psc_pres: pressure product, final scaling and saturation
// Four stages: split SENS*D1 partial products, their sum, the scaled
// pressure, then clamping of both results into the output register.
// ----------------------------------------------------------------------------
module psc_pres (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  psc_pkg::corr_res_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output psc_pkg::comp_res_t out_data
);
    import psc_pkg::*;

    localparam int NS = 4;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS:0]   adv;

    logic [PLO_W-1:0]         pp_lo;
    logic signed [PHI_W-1:0]  pp_hi;
    logic [PLO_W-1:0]         s7_lo_reg;
    logic [PHI_W-1:0]         s7_hi_reg;
    logic [CORR_W-1:0]        s7_off_reg;
    logic signed [TRAW_W-1:0] s7_temp_reg;

    logic [PROD_W-1:0]        prod_next;
    logic [PROD_W-1:0]        s8_prod_reg;
    logic [CORR_W-1:0]        s8_off_reg;
    logic signed [TRAW_W-1:0] s8_temp_reg;

    logic [PSH_W-1:0]         diff;
    logic signed [PRAW_W-1:0] s9_pres_reg;
    logic signed [TRAW_W-1:0] s9_temp_reg;

    logic                     t_lo;
    logic                     t_hi;
    logic                     p_lo;
    logic                     p_hi;
    comp_res_t                s10_reg;
    comp_res_t                s10_next;

    always_comb
    begin
        adv[NS] = out_ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            adv[i] = ~v_reg[i] | adv[i+1];
        end
    end

    assign v_next    = {v_reg[NS-2:0], in_valid};
    assign in_ready  = adv[0];
    assign out_valid = v_reg[NS-1];
    assign out_data  = s10_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (adv[i])
                begin
                    v_reg[i] <= v_next[i];
                end
            end
        end
    end

    // stage 7: signed upper half and unsigned lower half of SENS times D1
    assign pp_lo = in_data.sens[SPLIT-1:0] * in_data.d1;
    assign pp_hi = $signed(in_data.sens[CORR_W-1:SPLIT]) * $signed({1'b0, in_data.d1});

    // stage 8: recombine
    assign prod_next = {s7_hi_reg[PROD_W-SPLIT-1:0], {SPLIT{1'b0}}}
                     + {{(PROD_W-PLO_W){1'b0}}, s7_lo_reg};

    // stage 9: (prod/2^21 - OFF)/2^15, both floors
    assign diff = {s8_prod_reg[PROD_W-1], s8_prod_reg[PROD_W-1:PROD_SHIFT]}
                - {{(PSH_W-CORR_W){s8_off_reg[CORR_W-1]}}, s8_off_reg};

    // stage 10: clamp to the sensor range
    always_comb
    begin
        t_lo = (s9_temp_reg < TEMP_MIN);
        t_hi = (s9_temp_reg > TEMP_MAX);
        p_lo = s9_pres_reg[PRAW_W-1];
        p_hi = (s9_pres_reg > PRES_MAX);

        if (t_lo)
        begin
            s10_next.temp = TEMP_MIN[TEMP_W-1:0];
        end
        else if (t_hi)
        begin
            s10_next.temp = TEMP_MAX[TEMP_W-1:0];
        end
        else
        begin
            s10_next.temp = s9_temp_reg[TEMP_W-1:0];
        end

        if (p_lo)
        begin
            s10_next.pres = '0;
        end
        else if (p_hi)
        begin
            s10_next.pres = PRES_MAX[PRES_W-1:0];
        end
        else
        begin
            s10_next.pres = s9_pres_reg[PRES_W-1:0];
        end

        s10_next.sat = t_lo | t_hi | p_lo | p_hi;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s7_lo_reg   <= pp_lo;
            s7_hi_reg   <= pp_hi;
            s7_off_reg  <= in_data.off;
            s7_temp_reg <= in_data.temp;
        end
        if (adv[1])
        begin
            s8_prod_reg <= prod_next;
            s8_off_reg  <= s7_off_reg;
            s8_temp_reg <= s7_temp_reg;
        end
        if (adv[2])
        begin
            s9_pres_reg <= diff[PSH_W-1:PRES_SHIFT];
            s9_temp_reg <= s8_temp_reg;
        end
        if (adv[3])
        begin
            s10_reg <= s10_next;
        end
    end

endmodule

### src/pressure_sensor_compensation_top.sv
// ----------------------------------------------------------------------------
// pressure_sensor_compensation_top: second-order compensated temperature
// and pressure from raw sensor readings and six calibration words.
// Ten register stages. Throughput: one beat per clock while the output
// is not stalled; each stage moves on its own so bubbles close up while
// the output is stalled.
// Reset clears all stage valid bits and the calibration words.
// ----------------------------------------------------------------------------
module pressure_sensor_compensation_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic [psc_pkg::IDX_W-1:0]       cfg_index,
    input  logic [psc_pkg::CAL_W-1:0]       cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // raw_temperature [23:0], raw_pressure [47:24]
    input  logic [psc_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // temperature_centideg [14:0], pressure_tenth_mbar [32:15], zero fill
    output logic [psc_pkg::OUT_DATA_W-1:0]  m_tdata,
    // out_of_range [0]
    output logic [0:0]                      m_tuser
);
    import psc_pkg::*;

    cal_t      cal_reg;
    logic      temp_valid;
    logic      temp_ready;
    temp_res_t temp_data;
    logic      corr_valid;
    logic      corr_ready;
    corr_res_t corr_data;
    comp_res_t comp_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_C1:  cal_reg.c1 <= cfg_wdata;
                REG_C2:  cal_reg.c2 <= cfg_wdata;
                REG_C3:  cal_reg.c3 <= cfg_wdata;
                REG_C4:  cal_reg.c4 <= cfg_wdata;
                REG_C5:  cal_reg.c5 <= cfg_wdata;
                REG_C6:  cal_reg.c6 <= cfg_wdata;
                default: ;
            endcase
        end
    end

    psc_temp u_temp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cal       (cal_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_d2     (s_tdata[RAW_W-1:0]),
        .in_d1     (s_tdata[2*RAW_W-1:RAW_W]),
        .out_valid (temp_valid),
        .out_ready (temp_ready),
        .out_data  (temp_data)
    );

    psc_corr u_corr (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (temp_valid),
        .in_ready  (temp_ready),
        .in_data   (temp_data),
        .out_valid (corr_valid),
        .out_ready (corr_ready),
        .out_data  (corr_data)
    );

    psc_pres u_pres (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (corr_valid),
        .in_ready  (corr_ready),
        .in_data   (corr_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (comp_data)
    );

    assign m_tdata = {{(OUT_DATA_W-TEMP_W-PRES_W){1'b0}}, comp_data.pres, comp_data.temp};
    assign m_tuser = comp_data.sat;

endmodule

### src/psc_checker.sv
// ----------------------------------------------------------------------------
// psc_checker: port-level checks for pressure_sensor_compensation_top
// Output range, saturation flag consistency, ready behavior, output hold.
// ----------------------------------------------------------------------------
module psc_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [psc_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic [0:0]                      m_tuser
);
    import psc_pkg::*;

    logic signed [TEMP_W-1:0] out_temp;
    logic [PRES_W-1:0]        out_pres;

    assign out_temp = m_tdata[TEMP_W-1:0];
    assign out_pres = m_tdata[TEMP_W+PRES_W-1:TEMP_W];

    // results always inside the sensor range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_temp >= TEMP_MIN) && (out_temp <= TEMP_MAX)
                  && ({{(PRAW_W-PRES_W){1'b0}}, out_pres} <= PRES_MAX))
        else $error("compensated result outside sensor range");

    // a set flag means at least one result sits on a bound
    a_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (out_temp == TEMP_MIN) || (out_temp == TEMP_MAX)
                                || (out_pres == '0)
                                || (out_pres == PRES_MAX[PRES_W-1:0]))
        else $error("out_of_range set with both results inside the range");

    // an empty output stage lets the whole pipe move
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output stage is empty");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output beat changed or dropped");

endmodule

bind pressure_sensor_compensation_top psc_checker u_psc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### tb/sv/tb_pressure_sensor_compensation_top.sv
// ----------------------------------------------------------------------------
// tb_pressure_sensor_compensation_top: self-checking bench for the
// second-order compensated pressure and temperature pipeline
// Each accepted reading is run through an independent 64-bit model of the
// compensation and queued; every output beat is compared field by field
// against the oldest queued result. Calibration sets, idle patterns and a
// long output hold-off vary from one test to the next.
// ----------------------------------------------------------------------------
module tb_pressure_sensor_compensation_top;

    timeunit 1ns;
    timeprecision 1ps;

    import psc_pkg::*;

    localparam int    SETTLE_CYCLES = 16;
    localparam longint RUN_LIMIT_NS = 5_000_000;
    localparam logic [23:0] RAW_FULL = 24'hFFFFFF;

    // indexes past the calibration list, writes there must be dropped
    localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

    localparam cal_t TYPICAL_CAL = '{c1: 16'd46372, c2: 16'd43981, c3: 16'd29059,
                                     c4: 16'd27842, c5: 16'd31553, c6: 16'd28165};

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wen   = 1'b0;
    logic [IDX_W-1:0]      cfg_index = '0;
    logic [CAL_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;

    cal_t       cal_model = '0;
    comp_res_t  pending_results[$];
    comp_res_t  oldest_result;
    int         error_count    = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         hold_cycles    = 0;

    pressure_sensor_compensation_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("tb_pressure_sensor_compensation_top failed");
        $finish;
    end

    // exact 64-bit compensation, >>> on signed values is a floor
    function automatic comp_res_t predict_compensation(input cal_t c, input logic [23:0] d2,
                                                       input logic [23:0] d1);
        longint k1, k2, k3, k4, k5, k6, t_raw, p_raw;
        longint dt, temp, dev, low, t2, off2, sens2, off, sens, pres;
        logic   clipped;
        comp_res_t r;
        k1 = c.c1; k2 = c.c2; k3 = c.c3; k4 = c.c4; k5 = c.c5; k6 = c.c6;
        t_raw = d2;
        p_raw = d1;
        clipped = 1'b0;
        dt   = t_raw - k5 * 256;
        temp = 2000 + ((dt * k6) >>> 23);
        dev  = temp - 2000;
        if (temp < 2000)
        begin
            t2    = 3 * ((dt * dt) >>> 33);
            off2  = (3 * dev * dev) / 2;
            sens2 = (5 * dev * dev) / 8;
            if (temp < -1500)
            begin
                low   = temp + 1500;
                off2  = off2 + 7 * low * low;
                sens2 = sens2 + 4 * low * low;
            end
        end
        else
        begin
            t2    = (7 * dt * dt) >>> 37;
            off2  = (dev * dev) / 16;
            sens2 = 0;
        end
        off  = k2 * 65536 + ((k4 * dt) >>> 7) - off2;
        sens = k1 * 32768 + ((k3 * dt) >>> 8) - sens2;
        temp = temp - t2;
        pres = (((sens * p_raw) >>> 21) - off) >>> 15;
        if (temp < TEMP_MIN) begin temp = TEMP_MIN; clipped = 1'b1; end
        if (temp > TEMP_MAX) begin temp = TEMP_MAX; clipped = 1'b1; end
        if (pres < 0)        begin pres = 0;        clipped = 1'b1; end
        if (pres > PRES_MAX) begin pres = PRES_MAX; clipped = 1'b1; end
        r.temp = temp[TEMP_W-1:0];
        r.pres = pres[PRES_W-1:0];
        r.sat  = clipped;
        return r;
    endfunction

    function automatic cal_t jitter_cal();
        cal_t c;
        c = TYPICAL_CAL;
        c.c1 ^= 16'($urandom_range(16'h0FFF));
        c.c2 ^= 16'($urandom_range(16'h0FFF));
        c.c3 ^= 16'($urandom_range(16'h0FFF));
        c.c4 ^= 16'($urandom_range(16'h0FFF));
        c.c5 ^= 16'($urandom_range(16'h0FFF));
        c.c6 ^= 16'($urandom_range(16'h0FFF));
        return c;
    endfunction

    // leaves cfg_wen high, the caller drops it
    task automatic write_cal_word(input logic [IDX_W-1:0] idx, input logic [CAL_W-1:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            REG_C1:  cal_model.c1 = val;
            REG_C2:  cal_model.c2 = val;
            REG_C3:  cal_model.c3 = val;
            REG_C4:  cal_model.c4 = val;
            REG_C5:  cal_model.c5 = val;
            REG_C6:  cal_model.c6 = val;
            default: ;
        endcase
    endtask

    task automatic load_calibration(input cal_t c);
        write_cal_word(REG_C1, c.c1);
        write_cal_word(REG_C2, c.c2);
        write_cal_word(REG_C3, c.c3);
        write_cal_word(REG_C4, c.c4);
        write_cal_word(REG_C5, c.c5);
        write_cal_word(REG_C6, c.c6);
        write_cal_word(REG_SPARE_A, 16'($urandom_range(16'hFFFF)));
        write_cal_word(REG_SPARE_B, 16'($urandom_range(16'hFFFF)));
        cfg_wen <= 1'b0;
    endtask

    // called at a rising edge, returns at the edge that took the beat
    task automatic send_reading(input logic [23:0] raw_t, input logic [23:0] raw_p);
        logic taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {raw_p, raw_t};
        do
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end while (!taken);
        pending_results.push_back(predict_compensation(cal_model, raw_t, raw_p));
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int n, input int idle_pct, input int stall_pct);
        longint centre, raw_t;
        longint span;
        logic [23:0] raw_p;
        send_idle_pct  = idle_pct;
        recv_stall_pct <= stall_pct;
        centre = {cal_model.c5, 8'h00};
        repeat (n)
        begin
            case ($urandom_range(3))
                0:       span = -1;
                1:       span = 4096;
                2:       span = 1 << 20;
                default: span = 1 << 22;
            endcase
            if (span < 0)
                raw_t = $urandom_range(RAW_FULL);
            else
                raw_t = centre + longint'($urandom_range(2 * span)) - span;
            if (raw_t < 0)
                raw_t = 0;
            if (raw_t > RAW_FULL)
                raw_t = RAW_FULL;
            if ($urandom_range(1))
                raw_p = 24'($urandom_range(RAW_FULL));
            else
                raw_p = 24'($urandom_range(12_000_000, 3_000_000));
            send_reading(raw_t[23:0], raw_p);
        end
        wait_results_drained();
    endtask

    task automatic test_reset_calibration();
        send_reading(24'd0, 24'd0);
        send_reading(RAW_FULL, RAW_FULL);
        send_reading(24'd0, RAW_FULL);
        send_reading(RAW_FULL, 24'd0);
        wait_results_drained();
    endtask

    task automatic test_temperature_ranges();
        logic [23:0] ref_raw;
        load_calibration(TYPICAL_CAL);
        ref_raw = {TYPICAL_CAL.c5, 8'h00};
        send_reading(24'd8077636, 24'd6465444);
        // first-order temperature exactly 20.00 C, then just below it
        send_reading(ref_raw, 24'd6465444);
        send_reading(ref_raw - 24'd1, 24'd6465444);
        send_reading(24'd7928652, 24'd6465444);
        // well below -15.00 C
        send_reading(24'd7005368, 24'd6465444);
        send_reading(24'd9000000, 24'd9000000);
        send_reading(RAW_FULL, RAW_FULL);
        send_reading(24'd0, 24'd0);
        send_reading(24'd8077636, 24'd0);
        wait_results_drained();
    endtask

    task automatic test_extreme_calibration();
        load_calibration('1);
        send_reading(24'd0, 24'd0);
        send_reading(RAW_FULL, RAW_FULL);
        send_reading(24'd0, RAW_FULL);
        send_reading(RAW_FULL, 24'd0);
        wait_results_drained();
    endtask

    task automatic test_steady_stream();
        load_calibration(TYPICAL_CAL);
        run_phase(350, 0, 0);
    endtask

    task automatic test_sender_gaps();
        load_calibration(jitter_cal());
        run_phase(350, 62, 0);
    endtask

    task automatic test_receiver_stalls();
        cal_t c;
        c = cal_t'({$urandom, $urandom, $urandom});
        load_calibration(c);
        run_phase(350, 0, 62);
    endtask

    task automatic test_both_idle();
        load_calibration(jitter_cal());
        run_phase(350, 20, 20);
    endtask

    task automatic test_calibration_bounds();
        load_calibration('1);
        run_phase(150, 20, 20);
        load_calibration('0);
        run_phase(150, 62, 62);
    endtask

    // output held off long enough for the pipeline to fill and stall the input
    task automatic test_output_backpressure();
        load_calibration(jitter_cal());
        hold_cycles <= 400;
        run_phase(100, 0, 0);
    endtask

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // inputs only move at rising edges, so the negedge view is what the edge takes
    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected: tdata %h tuser %b", m_tdata, m_tuser);
                error_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (m_tdata[14:0] !== oldest_result.temp)
                begin
                    $error("temperature_centideg: expected %0d, got %0d",
                           oldest_result.temp, $signed(m_tdata[14:0]));
                    error_count++;
                end
                if (m_tdata[32:15] !== oldest_result.pres)
                begin
                    $error("pressure_tenth_mbar: expected %0d, got %0d",
                           oldest_result.pres, m_tdata[32:15]);
                    error_count++;
                end
                if (m_tuser[0] !== oldest_result.sat)
                begin
                    $error("out_of_range: expected %0b, got %0b", oldest_result.sat, m_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_calibration();
        test_temperature_ranges();
        test_extreme_calibration();
        test_steady_stream();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        test_calibration_bounds();
        test_output_backpressure();
        if (error_count == 0)
            $display("tb_pressure_sensor_compensation_top passed");
        else
            $display("tb_pressure_sensor_compensation_top failed");
        $finish;
    end

endmodule
